// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define CHK_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pse_pkg.sv -----
package pse_pkg;

    localparam int DATA_W     = 32;
    localparam int OPV_W      = 31;
    localparam int DEPTH_W    = 8;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 3'd0,
        FN_ADD    = 3'd1,
        FN_SUB    = 3'd2,
        FN_MUL    = 3'd3,
        FN_DIV    = 3'd4,
        FN_FINISH = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_OVER    = 2'd2,
        ST_DIVZERO = 2'd3
    } status_t;

    typedef struct packed {
        logic  start;
        func_t op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

endpackage

// ----- sv/pse_ram.sv -----
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/pse_alu.sv -----
module pse_alu
    import pse_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] opa,
    input  logic [DATA_W-1:0] opb,
    output alu_rsp_t          rsp
);

    localparam int IT_W = $clog2(DATA_W);

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_FIX,
        A_DONE
    } alu_state_t;

    alu_state_t        state_reg;
    logic [DATA_W-1:0] res_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dsr_reg;
    logic              neg_reg;
    logic [IT_W-1:0]   it_reg;

    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;

    assign mag_a = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
    assign mag_b = opb[DATA_W-1] ? (~opb + 1'b1) : opb;
    assign trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            unique case (state_reg)
                A_IDLE: begin
                    if (req.start) begin
                        unique case (req.op)
                            FN_ADD: begin
                                res_reg   <= opa + opb;
                                state_reg <= A_DONE;
                            end
                            FN_SUB: begin
                                res_reg   <= opa - opb;
                                state_reg <= A_DONE;
                            end
                            FN_MUL: begin
                                res_reg   <= opa * opb;
                                state_reg <= A_DONE;
                            end
                            FN_DIV: begin
                                quo_reg   <= mag_a;
                                dsr_reg   <= mag_b;
                                rem_reg   <= '0;
                                neg_reg   <= opa[DATA_W-1] ^ opb[DATA_W-1];
                                it_reg    <= '0;
                                state_reg <= A_DIV;
                            end
                            default: begin
                                res_reg   <= opb;
                                state_reg <= A_DONE;
                            end
                        endcase
                    end
                end
                A_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (!trial[DATA_W]) begin
                        rem_reg <= trial[DATA_W-1:0];
                        quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                        quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IT_W'(DATA_W - 1)) begin
                        state_reg <= A_FIX;
                    end
                end
                A_FIX: begin
                    res_reg   <= neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                    state_reg <= A_DONE;
                end
                A_DONE: begin
                    state_reg <= A_IDLE;
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = (state_reg == A_DONE);
    assign rsp.result = res_reg;

endmodule

// ----- sv/postfix_stack_evaluator.sv -----
// Postfix integer expression evaluator.
// Input channel (s_*): one token per transfer. s_tuser carries the function
// (0 push, 1 add, 2 sub, 3 mul, 4 div, 5 finish); s_tdata[30:0] the number
// to push. Output channel (m_*): one result per token, carrying top value,
// depth and status in m_tdata; m_tlast marks the final value of an expression.
// From an input transfer to m_tvalid: push, finish, underflow, overflow and
// ignored codes pass the result registers only; a divide by zero also passes
// the execute state; add, subtract and multiply also read the second operand
// from the stack memory and go through the arithmetic unit; divide goes
// through the radix-2 divider (one bit per cycle).
// One token is in work at a time, so a new token waits until the last one is
// through; it is taken while the previous result still waits on m_tready.
// The stack lives in a single-port-write RAM with registered read; the top
// entry is also held in a register so operators need one memory read.
// Reset (aresetn low, synchronous) empties the stack and drops any pending
// result. A stall on m_tready holds the result and, once the next token's
// result is ready, holds s_tready low until the output register frees up.
module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [30:0] operand_value, [31] zero
    input  logic [FUNC_W-1:0]    s_tuser,   // [2:0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] top_value, [39:32] depth,
                                            // [41:40] status, [47:42] zero
    output logic                 m_tlast    // done_res
);

    `include "assert_macros.svh"

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic [DATA_W-1:0] top_reg;
    func_t             func_reg;

    logic [DATA_W-1:0] res_top_reg;
    logic [CW-1:0]     res_count_reg;
    status_t           res_status_reg;
    logic              res_done_reg;

    logic                m_tvalid_reg;
    logic [DATA_W-1:0]   m_top_reg;
    logic [DEPTH_W-1:0]  m_depth_reg;
    status_t             m_status_reg;
    logic                m_done_reg;

    logic [CW-1:0]     count_m2;
    logic [DATA_W-1:0] top_or_zero;
    logic              full;
    logic              s_fire;
    func_t             s_func;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    assign count_m2    = count_reg - CW'(2);
    assign top_or_zero = (count_reg == '0) ? '0 : top_reg;
    assign full        = (count_reg >= CW'(STACK_DEPTH));
    assign s_tready    = (state_reg == S_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign s_func      = func_t'(s_tuser);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_m2[AW-1:0];
        ram_wdata = alu_rsp.result;
        if (s_fire && (s_func == FN_PUSH) && !full) begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[AW-1:0];
            ram_wdata = {1'b0, s_tdata[OPV_W-1:0]};
        end else if ((state_reg == S_WAIT) && alu_rsp.done) begin
            ram_we    = 1'b1;
        end
    end

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (count_m2[AW-1:0]),
        .rd_data (ram_rdata)
    );

    assign alu_req.start = (state_reg == S_EXEC) &&
                           !((func_reg == FN_DIV) && (top_reg == '0));
    assign alu_req.op    = func_reg;

    pse_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (ram_rdata),
        .opb     (top_reg),
        .rsp     (alu_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        func_reg       <= s_func;
                        res_status_reg <= ST_OK;
                        res_done_reg   <= 1'b0;
                        res_top_reg    <= top_or_zero;
                        res_count_reg  <= count_reg;
                        state_reg      <= S_OUT;
                        unique case (s_func) inside
                            FN_PUSH: begin
                                if (full) begin
                                    res_status_reg <= ST_OVER;
                                end else begin
                                    top_reg       <= {1'b0, s_tdata[OPV_W-1:0]};
                                    count_reg     <= count_reg + 1'b1;
                                    res_top_reg   <= {1'b0, s_tdata[OPV_W-1:0]};
                                    res_count_reg <= count_reg + 1'b1;
                                end
                            end
                            FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
                                if (count_reg < CW'(2)) begin
                                    res_status_reg <= ST_UNDER;
                                end else begin
                                    state_reg <= S_EXEC;
                                end
                            end
                            FN_FINISH: begin
                                if (count_reg == '0) begin
                                    res_status_reg <= ST_UNDER;
                                end else begin
                                    count_reg     <= '0;
                                    res_count_reg <= '0;
                                    res_done_reg  <= 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_EXEC: begin
                    if ((func_reg == FN_DIV) && (top_reg == '0)) begin
                        res_status_reg <= ST_DIVZERO;
                        state_reg      <= S_OUT;
                    end else begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        top_reg       <= alu_rsp.result;
                        count_reg     <= count_reg - 1'b1;
                        res_top_reg   <= alu_rsp.result;
                        res_count_reg <= count_reg - 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_top_reg    <= res_top_reg;
                        m_depth_reg  <= DEPTH_W'(res_count_reg);
                        m_status_reg <= res_status_reg;
                        m_done_reg   <= res_done_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - DEPTH_W - STATUS_W){1'b0}},
                       m_status_reg, m_depth_reg, m_top_reg};
    assign m_tlast  = m_done_reg;

    `CHK_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CW'(STACK_DEPTH),
                "stack count beyond depth")
    `CHK_ALWAYS(a_alu_done_wait, aclk, aresetn, !alu_rsp.done || (state_reg == S_WAIT),
                "arithmetic result outside wait")
    `CHK_ALWAYS(a_push_room, aclk, aresetn, !(ram_we && (state_reg == S_IDLE)) || !full,
                "push written into full stack")
    `CHK_ALWAYS(a_exec_operands, aclk, aresetn,
                (state_reg != S_EXEC) || (count_reg >= CW'(2)),
                "operator with fewer than two entries")
    `CHK_NEXT(a_wait_pops, aclk, aresetn, (state_reg == S_WAIT) && alu_rsp.done,
              count_reg == $past(count_reg) - 1'b1, "operator did not pop one entry")

endmodule

// ----- verif/tb_postfix_stack_evaluator.sv -----
module tb_postfix_stack_evaluator;
    import pse_pkg::*;

    localparam int STACK_DEPTH    = 128;
    localparam int WATCHDOG_LIMIT = 2000;

    // func codes the block ignores
    localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;
    localparam logic [OPV_W-1:0]  OPV_MAX   = {OPV_W{1'b1}};

    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [OPV_W-1:0]  opv;
    } token_t;

    typedef struct packed {
        logic [DATA_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
        status_t            status;
        logic               done;
    } eval_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    token_t       token_q[$];
    eval_result_t pending_results[$];
    token_t       tx_token;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int unsigned       stack_cnt    = 0;

    int tx_idle_pct  = 20;
    int rx_idle_pct  = 20;
    int errors       = 0;
    int stall_cycles = 0;
    int gen_depth    = 0;
    int gen_count    = 0;

    always #4 aclk = ~aclk;

    postfix_stack_evaluator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // signed division truncating toward zero, wrapping on min / -1
    function automatic logic [DATA_W-1:0] trunc_div(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [DATA_W-1:0] q;
        ma = a[DATA_W-1] ? -a : a;
        mb = b[DATA_W-1] ? -b : b;
        q  = ma / mb;
        return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
    endfunction

    function automatic eval_result_t evaluate_token(input token_t t);
        eval_result_t r;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] v;
        r.status = ST_OK;
        r.done   = 1'b0;
        r.top    = '0;
        v        = '0;
        if (t.fn == FN_PUSH) begin
            if (stack_cnt >= STACK_DEPTH) begin
                r.status = ST_OVER;
            end else begin
                stack_mem[stack_cnt] = {1'b0, t.opv};
                stack_cnt++;
            end
        end else if (t.fn >= FN_ADD && t.fn <= FN_DIV) begin
            if (stack_cnt < 2) begin
                r.status = ST_UNDER;
            end else begin
                b = stack_mem[stack_cnt-1];
                a = stack_mem[stack_cnt-2];
                case (t.fn)
                    FN_ADD: v = a + b;
                    FN_SUB: v = a - b;
                    FN_MUL: v = a * b;
                    default: begin
                        if (b == '0) r.status = ST_DIVZERO;
                        else v = trunc_div(a, b);
                    end
                endcase
                if (r.status == ST_OK) begin
                    stack_mem[stack_cnt-2] = v;
                    stack_cnt--;
                end
            end
        end else if (t.fn == FN_FINISH) begin
            if (stack_cnt == 0) begin
                r.status = ST_UNDER;
            end else begin
                r.top     = stack_mem[stack_cnt-1];
                r.done    = 1'b1;
                stack_cnt = 0;
            end
        end
        if (!r.done) r.top = (stack_cnt == 0) ? '0 : stack_mem[stack_cnt-1];
        r.depth = DEPTH_W'(stack_cnt);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) pending_results.push_back(evaluate_token(tx_token));
            if (!s_tvalid || s_tready) begin
                if (token_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    tx_token = token_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= tx_token.fn;
                    s_tdata  <= {1'b0, tx_token.opv};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        eval_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer: expected none, actual %0h",
                             $time, m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    check_field("top_value", want.top, m_tdata[31:0]);
                    check_field("depth", DATA_W'(want.depth), DATA_W'(m_tdata[39:32]));
                    check_field("status", DATA_W'(want.status), DATA_W'(m_tdata[41:40]));
                    check_field("done", DATA_W'(want.done), DATA_W'(m_tlast));
                end
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_postfix_stack_evaluator failed");
            $finish;
        end
    end

    task automatic add_token(input logic [FUNC_W-1:0] fn, input logic [OPV_W-1:0] opv);
        token_t t;
        t.fn  = fn;
        t.opv = opv;
        token_q.push_back(t);
        gen_count++;
        // rough depth estimate for shaping expressions
        case (fn)
            FN_PUSH:                    if (gen_depth < STACK_DEPTH) gen_depth++;
            FN_ADD, FN_SUB, FN_MUL, FN_DIV: if (gen_depth >= 2) gen_depth--;
            FN_FINISH:                  gen_depth = 0;
            default: ;
        endcase
    endtask

    function automatic logic [OPV_W-1:0] random_operand();
        case ($urandom_range(9))
            0:       return '0;
            1:       return OPV_MAX;
            2, 3, 4: return OPV_W'($urandom_range(1, 20));
            default: return OPV_W'($urandom);
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] random_operator();
        return FUNC_W'($urandom_range(FN_ADD, FN_DIV));
    endfunction

    task automatic gen_expression();
        int max_d;
        int n_ops;
        max_d = $urandom_range(2, 8);
        n_ops = $urandom_range(1, 12);
        add_token(FN_PUSH, random_operand());
        while (n_ops > 0) begin
            if (gen_depth < 2 || (gen_depth < max_d && $urandom_range(99) < 45)) begin
                add_token(FN_PUSH, random_operand());
            end else begin
                add_token(random_operator(), OPV_W'($urandom));
                n_ops--;
            end
        end
        while (gen_depth > 1) add_token(random_operator(), OPV_W'($urandom));
        add_token(FN_FINISH, OPV_W'($urandom));
    endtask

    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) add_token(FUNC_W'($urandom_range(7)), random_operand());
    endtask

    // fill to capacity, push past it, then unwind
    task automatic gen_fill();
        add_token(FN_FINISH, '0);
        while (gen_depth < STACK_DEPTH) add_token(FN_PUSH, random_operand());
        repeat (2) add_token(FN_PUSH, random_operand());
        repeat (5) add_token(random_operator(), OPV_W'($urandom));
        add_token(FN_FINISH, '0);
    endtask

    task automatic gen_random(input int n);
        int stop;
        stop = gen_count + n;
        while (gen_count < stop) begin
            if ($urandom_range(99) < 85) gen_expression();
            else gen_noise();
        end
    endtask

    task automatic wait_drained();
        while (token_q.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        add_token(FN_FINISH, '0);
        add_token(FN_ADD, OPV_MAX);
        add_token(FN_PUSH, '0);
        add_token(FN_MUL, '0);
        add_token(FN_PUSH, OPV_MAX);
        add_token(FN_SUB, '0);
        add_token(FN_PUSH, 31'd1);
        add_token(FN_SUB, '0);          // most negative value
        add_token(FN_PUSH, '0);
        add_token(FN_DIV, '0);          // zero divisor
        add_token(FN_SPARE6, OPV_MAX);
        add_token(FN_PUSH, 31'd1);
        add_token(FN_SUB, '0);
        add_token(FN_DIV, '0);          // min / -1
        add_token(FN_PUSH, OPV_MAX);
        add_token(FN_ADD, '0);
        add_token(FN_PUSH, OPV_MAX);
        add_token(FN_MUL, '0);
        add_token(FN_PUSH, 31'd3);
        add_token(FN_DIV, OPV_MAX);
        add_token(FN_SPARE7, OPV_MAX);
        add_token(FN_FINISH, OPV_MAX);
        wait_drained();

        gen_random(700);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        gen_fill();
        gen_random(300);
        wait_drained();

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        gen_fill();
        gen_random(550);
        wait_drained();

        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_postfix_stack_evaluator passed");
        end else begin
            $display("tb_postfix_stack_evaluator failed");
        end
        $finish;
    end

endmodule
